// File: rtl/core/pps_pkg.sv
// Shared types and constants of the periodic poll scheduler.
package pps_pkg;
  localparam int NumSlots   = 16;
  localparam int PeriodBits = 16;
  localparam int SlotBits   = $clog2(NumSlots);
  localparam int AccBits    = 32;
  localparam logic [AccBits-1:0] AccMax = '1;

  localparam logic [1:0] ReqAdd    = 2'd0;
  localparam logic [1:0] ReqRemove = 2'd1;
  localparam logic [1:0] ReqTick   = 2'd2;

  // Command broadcast from the sequencer to every cell.
  typedef struct packed {
    logic                  add_en;
    logic                  rem_en;
    logic [SlotBits-1:0]   sel;
    logic [PeriodBits-1:0] period;
  } cell_cmd_t;
endpackage

// File: rtl/core/pps_if.sv
// Valid/ready channel interfaces of the periodic poll scheduler.
interface pps_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [3:0]  slot;
  logic [15:0] period;
  logic [15:0] elapsed_ms;
  modport source (output valid, req_type, slot, period, elapsed_ms, input ready);
  modport sink   (input valid, req_type, slot, period, elapsed_ms, output ready);
endinterface

interface pps_res_if;
  logic        valid;
  logic        ready;
  logic        fired;
  logic [3:0]  due_slot;
  logic [15:0] base_period;
  logic        last;
  modport source (output valid, fired, due_slot, base_period, last, input ready);
  modport sink   (input valid, fired, due_slot, base_period, last, output ready);
endinterface

interface pps_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: rtl/core/pps_cell.sv
// One slot cell: holds a slot's state and answers for it when selected.
module pps_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [pps_pkg::SlotBits-1:0]        my_idx,
  input  pps_pkg::cell_cmd_t                  cmd,
  input  logic                                step,
  input  logic [pps_pkg::SlotBits-1:0]        step_idx,
  input  logic [pps_pkg::AccBits-1:0]         pend,
  output logic                                used,
  output logic                                fire,
  output logic [pps_pkg::PeriodBits-1:0]      period_out
);
  logic [pps_pkg::PeriodBits-1:0] period;
  logic [pps_pkg::AccBits-1:0]    accum;
  logic [pps_pkg::AccBits:0]      sum;
  logic [pps_pkg::AccBits-1:0]    acc_sat;
  logic                           hit;

  // Saturating accumulate and due check for this slot.
  assign sum     = {1'b0, accum} + {1'b0, pend};
  assign acc_sat = sum[pps_pkg::AccBits] ? pps_pkg::AccMax : sum[pps_pkg::AccBits-1:0];
  assign hit     = step && (step_idx == my_idx) && used;
  assign fire    = hit && (acc_sat >= {{(pps_pkg::AccBits-pps_pkg::PeriodBits){1'b0}}, period});
  assign period_out = period;

  // Used bit resets; payload is written by add.
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (cmd.add_en && cmd.sel == my_idx) begin
      used <= 1'b1;
    end else if (cmd.rem_en && cmd.sel == my_idx) begin
      used <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_en && cmd.sel == my_idx) begin
      period <= cmd.period;
      accum  <= '0;
    end else if (hit) begin
      accum <= fire ? '0 : acc_sat;
    end
  end
endmodule

// File: rtl/core/pps_gcd.sv
// Iterative GCD unit: one subtract-or-swap step per cycle while busy.
module pps_gcd (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [pps_pkg::PeriodBits-1:0] a_in,
  input  logic [pps_pkg::PeriodBits-1:0] b_in,
  output logic                           done,
  output logic [pps_pkg::PeriodBits-1:0] result
);
  logic [pps_pkg::PeriodBits-1:0] a;
  logic [pps_pkg::PeriodBits-1:0] b;
  logic                           busy;

  // Euclid by subtraction; gcd(a,0)=a.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a    <= a_in;
        b    <= b_in;
        busy <= 1'b1;
      end else if (busy) begin
        if (b == '0) begin
          busy   <= 1'b0;
          done   <= 1'b1;
          result <= a;
        end else if (a < b) begin
          a <= b;
          b <= a;
        end else begin
          a <= a - b;
        end
      end
    end
  end
endmodule

// File: rtl/core/periodic_poll_scheduler.sv
// Top level of the periodic poll scheduler.
// Usage: requests enter on req (add, remove, tick); results leave on res;
// the initial_period register is written through cfg while idle.
// Each add or remove gives one acknowledgement word with last set. A remove
// is acknowledged by a word loaded from the ACK state once the result
// register is free. An add first scans the sixteen slot cells, one cell per
// cycle unless a GCD is pending; each used cell after the first starts the
// subtractive GCD unit and the scan waits in GCD_WAIT until it is done, so
// the length of an add depends on the periods. Its acknowledgement is sent
// from the ACK state after the scan.
// A tick adds elapsed time to a pending counter; once it reaches the base
// period the sequencer walks the cells in order, one cell per cycle while the
// receiver keeps up. Due words are held one firing behind so the last flag
// can be set; the final one leaves from the flush state.
// One item is processed at a time; req is ready only when the sequencer
// idles and no result word waits.
// A stalled receiver holds the walk at the current cell until the word is taken.
// Synchronous reset clears all used bits, the base period and pending time,
// and sets initial_period to 100; no clearing pass is needed.
module periodic_poll_scheduler (
  input logic clk,
  input logic rst,
  pps_req_if.sink   req,
  pps_res_if.source res,
  pps_cfg_if.sink   cfg
);
  typedef enum logic [2:0] {S_IDLE, S_GCD_SCAN, S_GCD_WAIT, S_WALK, S_ACK, S_FLUSH} state_t;
  localparam int SB = pps_pkg::SlotBits;
  localparam int PB = pps_pkg::PeriodBits;
  localparam int AB = pps_pkg::AccBits;

  state_t                state;
  logic [15:0]           init_period;
  logic                  base_valid;
  logic [PB-1:0]         base_gcd;
  logic [AB-1:0]         pending;
  logic [SB-1:0]         idx;
  logic [PB-1:0]         g;
  logic                  g_first;
  logic                  any_fire;
  logic [SB-1:0]         last_fire;

  logic [pps_pkg::NumSlots-1:0] used;
  logic [pps_pkg::NumSlots-1:0] fire;
  logic [PB-1:0]         per [pps_pkg::NumSlots];
  pps_pkg::cell_cmd_t    cmd;
  logic                  step;
  logic                  gstart;
  logic                  gdone;
  logic [PB-1:0]         gres;
  logic [AB:0]           psum;
  logic [AB-1:0]         pend_new;
  logic [15:0]           cur_base;
  logic                  acc;
  logic                  emit;
  logic                  emit_fired;
  logic [SB-1:0]         emit_slot;
  logic                  emit_last;

  assign cfg.ready = (state == S_IDLE);
  assign req.ready = (state == S_IDLE) && !res.valid;
  assign acc       = req.valid && req.ready;
  assign cur_base  = base_valid ? base_gcd : init_period;
  assign psum      = {1'b0, pending} + {{(AB-15){1'b0}}, req.elapsed_ms};
  assign pend_new  = psum[AB] ? pps_pkg::AccMax : psum[AB-1:0];

  // Commands broadcast to the cells on an accepted add or remove.
  always_comb begin
    cmd.add_en = acc && req.req_type == pps_pkg::ReqAdd;
    cmd.rem_en = acc && req.req_type == pps_pkg::ReqRemove;
    cmd.sel    = req.slot;
    cmd.period = req.period;
  end

  // Walk steps advance unless a due word waits for the receiver.
  assign step = (state == S_WALK) && !(res.valid && !res.ready);

  // Word to load into the result register in this cycle, if any.
  always_comb begin
    emit       = 1'b0;
    emit_fired = 1'b0;
    emit_slot  = '0;
    emit_last  = 1'b0;
    unique case (state)
      S_ACK: begin
        emit      = !res.valid || res.ready;
        emit_last = 1'b1;
      end
      S_WALK: begin
        emit       = step && fire[idx] && any_fire;
        emit_fired = 1'b1;
        emit_slot  = last_fire;
      end
      S_FLUSH: begin
        emit       = !res.valid || res.ready;
        emit_fired = 1'b1;
        emit_slot  = last_fire;
        emit_last  = 1'b1;
      end
      default: ;
    endcase
  end

  for (genvar i = 0; i < pps_pkg::NumSlots; i++) begin : g_cell
    pps_cell u_cell (
      .clk(clk), .rst(rst), .my_idx(SB'(i)), .cmd(cmd), .step(step),
      .step_idx(idx), .pend(pending), .used(used[i]), .fire(fire[i]),
      .period_out(per[i])
    );
  end

  pps_gcd u_gcd (
    .clk(clk), .rst(rst), .start(gstart), .a_in(g), .b_in(per[idx]),
    .done(gdone), .result(gres)
  );
  assign gstart = (state == S_GCD_SCAN) && used[idx] && !g_first;

  // Sequencer; fired words are held one firing behind to place the last flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      init_period <= 16'd100;
      base_valid  <= 1'b0;
      base_gcd    <= '0;
      pending     <= '0;
      res.valid   <= 1'b0;
      any_fire    <= 1'b0;
    end else begin
      if (emit) begin
        res.valid       <= 1'b1;
        res.fired       <= emit_fired;
        res.due_slot    <= 4'(emit_slot);
        res.base_period <= cur_base;
        res.last        <= emit_last;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
      if (cfg.valid && cfg.ready) init_period <= cfg.data;
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            unique case (req.req_type)
              pps_pkg::ReqAdd: begin
                if (32'(req.slot) < pps_pkg::NumSlots) begin
                  state   <= S_GCD_SCAN;
                  idx     <= '0;
                  g_first <= 1'b1;
                  g       <= '0;
                end else state <= S_ACK;
              end
              pps_pkg::ReqRemove: state <= S_ACK;
              pps_pkg::ReqTick: begin
                pending <= pend_new;
                if (pend_new >= {{(AB-16){1'b0}}, cur_base}) begin
                  state    <= S_WALK;
                  idx      <= '0;
                  any_fire <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        S_GCD_SCAN: begin
          if (used[idx] && !g_first) begin
            state <= S_GCD_WAIT;
          end else begin
            if (used[idx]) begin
              g       <= per[idx];
              g_first <= 1'b0;
            end
            if (idx == SB'(pps_pkg::NumSlots-1)) begin
              base_gcd   <= used[idx] && g_first ? per[idx] : g;
              base_valid <= 1'b1;
              state      <= S_ACK;
            end else idx <= idx + 1'b1;
          end
        end
        S_GCD_WAIT: begin
          if (gdone) begin
            g <= gres;
            if (idx == SB'(pps_pkg::NumSlots-1)) begin
              base_gcd   <= gres;
              base_valid <= 1'b1;
              state      <= S_ACK;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_GCD_SCAN;
            end
          end
        end
        S_ACK: begin
          if (!res.valid || res.ready) state <= S_IDLE;
        end
        S_WALK: begin
          if (step) begin
            if (fire[idx]) begin
              any_fire  <= 1'b1;
              last_fire <= idx;
            end
            if (idx == SB'(pps_pkg::NumSlots-1)) begin
              pending <= '0;
              state   <= (any_fire || fire[idx]) ? S_FLUSH : S_IDLE;
            end else idx <= idx + 1'b1;
          end
        end
        // The held firing goes out as the final word of the walk.
        S_FLUSH: begin
          if (!res.valid || res.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A result word stays valid and keeps its due slot while stalled.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |=> res.valid && $stable(res.due_slot))
    else $error("result changed while stalled");
  // No request is taken while a walk or GCD pass runs.
  a_idle: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> state == S_IDLE)
    else $error("request taken while busy");
  // Acknowledgements always carry last set and due slot zero.
  a_ack: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.fired |-> res.last && res.due_slot == 4'd0)
    else $error("malformed acknowledgement");
endmodule

// File: sim/tb_periodic_poll_scheduler.sv
// Self-checking testbench of the periodic poll scheduler with a scoreboard class.
module tb_periodic_poll_scheduler;

  typedef struct {
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic [15:0] period;
    logic [15:0] elapsed;
  } poll_req_t;

  typedef struct {
    logic        fired;
    logic [3:0]  due_slot;
    logic [15:0] base_period;
    logic        last;
  } poll_res_t;

  localparam logic [1:0] ReqBad = 2'd3;

  // Scoreboard: keeps its own copy of the slot table and the result words it implies.
  class poll_scoreboard;
    logic [15:0] init_period;
    bit          used [pps_pkg::NumSlots];
    logic [15:0] per [pps_pkg::NumSlots];
    logic [31:0] acc [pps_pkg::NumSlots];
    bit          have_base;
    logic [15:0] gcd_base;
    logic [31:0] pend_ms;
    poll_res_t   due_words [$];
    int          errors;
    int          words_seen;
    int          fire_count;

    function new();
      init_period = 16'd100;
      have_base = 0;
      gcd_base = '0;
      pend_ms = '0;
      errors = 0;
      words_seen = 0;
      fire_count = 0;
      foreach (used[i]) begin
        used[i] = 0;
        per[i] = '0;
        acc[i] = '0;
      end
    endfunction

    function logic [31:0] euclid(logic [31:0] a, logic [31:0] b);
      logic [31:0] t;
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      return a;
    endfunction

    function logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? pps_pkg::AccMax : s[31:0];
    endfunction

    function logic [15:0] base_now();
      return have_base ? gcd_base : init_period;
    endfunction

    function void push_word(logic f, logic [3:0] s);
      poll_res_t w;
      w.fired = f;
      w.due_slot = s;
      w.base_period = base_now();
      w.last = 1'b0;
      due_words.insert(due_words.size(), w);
    endfunction

    // Works out the words that one accepted request causes.
    function void note_request(poll_req_t r);
      bit          first;
      logic [31:0] g;
      int          n;
      case (r.kind)
        pps_pkg::ReqAdd: begin
          used[r.slot] = 1;
          per[r.slot] = r.period;
          acc[r.slot] = '0;
          first = 1;
          g = '0;
          for (int i = 0; i < pps_pkg::NumSlots; i++) begin
            if (used[i]) begin
              g = first ? 32'(per[i]) : euclid(g, 32'(per[i]));
              first = 0;
            end
          end
          gcd_base = g[15:0];
          have_base = 1;
          push_word(1'b0, 4'd0);
          due_words[$].last = 1'b1;
        end
        pps_pkg::ReqRemove: begin
          used[r.slot] = 0;
          push_word(1'b0, 4'd0);
          due_words[$].last = 1'b1;
        end
        pps_pkg::ReqTick: begin
          pend_ms = sat_sum(pend_ms, 32'(r.elapsed));
          if (pend_ms >= 32'(base_now())) begin
            n = 0;
            for (int i = 0; i < pps_pkg::NumSlots; i++) begin
              if (used[i]) begin
                acc[i] = sat_sum(acc[i], pend_ms);
                if (acc[i] >= 32'(per[i])) begin
                  acc[i] = '0;
                  push_word(1'b1, 4'(i));
                  n++;
                end
              end
            end
            pend_ms = '0;
            if (n > 0) due_words[$].last = 1'b1;
            fire_count += n;
          end
        end
        default: ;
      endcase
    endfunction

    // Compares one accepted word against the oldest expected one.
    function void check_result(poll_res_t got);
      poll_res_t exp_w;
      words_seen++;
      if (due_words.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected word: fired=%0b slot=%0d base=%0d last=%0b",
                   got.fired, got.due_slot, got.base_period, got.last);
        return;
      end
      exp_w = due_words.pop_front();
      if (got.fired !== exp_w.fired || got.due_slot !== exp_w.due_slot ||
          got.base_period !== exp_w.base_period || got.last !== exp_w.last) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: expected fired=%0b slot=%0d base=%0d last=%0b,",
                    " got %0b %0d %0d %0b"},
                   exp_w.fired, exp_w.due_slot, exp_w.base_period, exp_w.last,
                   got.fired, got.due_slot, got.base_period, got.last);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  pps_req_if req ();
  pps_res_if res ();
  pps_cfg_if cfg ();

  poll_scoreboard sb;
  bit hold_req;
  int sent;

  periodic_poll_scheduler u_top (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .res (res.source),
    .cfg (cfg.sink)
  );

  // Clock with a period of 10.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result monitor.
  always @(posedge clk) begin
    poll_res_t w;
    if (!rst && res.valid && res.ready) begin
      w.fired = res.fired;
      w.due_slot = res.due_slot;
      w.base_period = res.base_period;
      w.last = res.last;
      sb.check_result(w);
    end
  end

  // Receiver: random stalls, plus one long hold-off when asked.
  initial begin
    int g;
    res.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        res.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end else begin
        g = pick_gap();
        if (g == 0) begin
          res.ready <= 1'b1;
        end else begin
          res.ready <= 1'b0;
          repeat (g - 1) @(posedge clk);
        end
      end
    end
  end

  // Offers one request and waits for it to be taken; called at a rising edge.
  task automatic send_req(poll_req_t it);
    int g;
    req.valid <= 1'b1;
    req.req_type <= it.kind;
    req.slot <= it.slot;
    req.period <= it.period;
    req.elapsed_ms <= it.elapsed;
    do @(posedge clk); while (!req.ready);
    sb.note_request(it);
    sent++;
    g = pick_gap();
    if (g > 0) begin
      req.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send(logic [1:0] k, logic [3:0] s, logic [15:0] p, logic [15:0] e);
    poll_req_t it;
    it.kind = k;
    it.slot = s;
    it.period = p;
    it.elapsed = e;
    send_req(it);
  endtask

  // Stops offering and waits until every expected word has come.
  task automatic drain();
    req.valid <= 1'b0;
    while (sb.due_words.size() != 0) @(posedge clk);
  endtask

  // Writes initial_period once the block has settled.
  task automatic write_initial(logic [15:0] v);
    drain();
    repeat (64) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.data <= v;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    sb.init_period = v;
  endtask

  function automatic logic [15:0] rand_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return 16'($urandom_range(1, 65535));
    if (r < 85) return 16'($urandom_range(1, 6) * $urandom_range(1, 12));
    return 16'($urandom_range(1, 300));
  endfunction

  function automatic logic [15:0] rand_elapsed();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 16'($urandom_range(0, 65535));
    if (r < 10) return 16'd0;
    return 16'($urandom_range(1, 40));
  endfunction

  // Main stimulus.
  initial begin
    int r;
    sb = new();
    hold_req = 0;
    sent = 0;
    rst = 1'b1;
    req.valid = 1'b0;
    req.req_type = pps_pkg::ReqAdd;
    req.slot = '0;
    req.period = '0;
    req.elapsed_ms = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Before any add the register sets the base; try both extremes.
    write_initial(16'd1);
    send(pps_pkg::ReqTick, 4'd0, 16'd0, 16'd0);
    send(pps_pkg::ReqTick, 4'd0, 16'd0, 16'd1);
    send(ReqBad, 4'd15, 16'hFFFF, 16'hFFFF);
    write_initial(16'hFFFF);
    send(pps_pkg::ReqTick, 4'd0, 16'd0, 16'hFFFE);
    send(pps_pkg::ReqTick, 4'd0, 16'd0, 16'd1);
    write_initial(16'($urandom_range(1, 65535)));
    send(pps_pkg::ReqTick, 4'd0, 16'd0, 16'd50);

    // Directed adds, removes and ticks: extreme slots and periods, free removes, an unknown code.
    send(pps_pkg::ReqRemove, 4'd3, 16'd0, 16'd0);
    send(pps_pkg::ReqAdd, 4'd0, 16'd1, 16'd0);
    send(pps_pkg::ReqTick, 4'd0, 16'd0, 16'd1);
    send(pps_pkg::ReqAdd, 4'd15, 16'hFFFF, 16'd0);
    send(pps_pkg::ReqTick, 4'd0, 16'd0, 16'hFFFF);
    send(pps_pkg::ReqAdd, 4'd15, 16'd6, 16'd0);
    send(pps_pkg::ReqAdd, 4'd0, 16'd4, 16'd0);
    send(pps_pkg::ReqTick, 4'd0, 16'd0, 16'd1);
    send(pps_pkg::ReqTick, 4'd0, 16'd0, 16'd3);
    send(pps_pkg::ReqTick, 4'd0, 16'd0, 16'd4);
    send(pps_pkg::ReqRemove, 4'd0, 16'd0, 16'd0);
    send(pps_pkg::ReqRemove, 4'd15, 16'd0, 16'd0);
    send(pps_pkg::ReqTick, 4'd0, 16'd0, 16'd7);
    send(ReqBad, 4'd5, 16'd10, 16'd10);
    drain();

    // Random part: mostly table churn and ticks.
    for (int n = 0; n < 80; n++) begin
      if (n == 30) hold_req = 1;
      if (n == 60) drain();
      r = $urandom_range(0, 99);
      if (r < 30) send(pps_pkg::ReqAdd, 4'($urandom_range(0, 15)), rand_period(),
                       16'($urandom_range(0, 65535)));
      else if (r < 42) send(pps_pkg::ReqRemove, 4'($urandom_range(0, 15)),
                            16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      else if (r < 96) send(pps_pkg::ReqTick, 4'($urandom_range(0, 15)),
                            16'($urandom_range(0, 65535)), rand_elapsed());
      else send(ReqBad, 4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535)));
    end

    drain();
    repeat (100) @(posedge clk);
    $display("Covered %0d requests (adds, removes, ticks, unknown codes) and %0d words,",
             sent, sb.words_seen);
    $display("%0d of them due-slot words, across three initial period settings.",
             sb.fire_count);
    if (sb.errors == 0 && sb.due_words.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d words missing", sb.errors, sb.due_words.size());
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000000;
    $display("timeout");
    $display("simulation failed");
    $finish;
  end
endmodule
